// ----- hdl/trc_pkg.sv -----
// Shared types and constants for the tiny 8-bit RISC core.
package trc_pkg;

    localparam int XLEN      = 8;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    // What an incoming request carries
    typedef enum logic [1:0] {
        KIND_EXEC    = 2'd0,
        KIND_PRE_REG = 2'd1,
        KIND_PRE_MEM = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Instruction opcodes; codes 12 to 14 are no-ops
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_INC   = 4'd3,
        OP_AND   = 4'd4,
        OP_OR    = 4'd5,
        OP_NOT   = 4'd6,
        OP_XOR   = 4'd7,
        OP_LOAD  = 4'd8,
        OP_STORE = 4'd9,
        OP_JMP   = 4'd10,
        OP_BEQZ  = 4'd11,
        OP_HALT  = 4'd15
    } t_opcode;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_MEM  = 2'd2
    } t_state;

    // Decoded request held in the queue
    typedef struct packed {
        t_kind             kind;
        t_opcode           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [REG_AW-1:0] rb;     // second register read port address
        logic [7:0]        pidx;
        logic [XLEN-1:0]   pval;
    } t_item;

    // One result
    typedef struct packed {
        logic [7:0]        next_pc;
        logic              reg_written;
        logic [REG_AW-1:0] written_reg;
        logic [XLEN-1:0]   written_value;
        logic              mem_written;
        logic              branch_taken;
        logic              halted;
    } t_result;

endpackage

// ----- hdl/tiny_8bit_risc_core_top.sv -----
// Tiny 8-bit RISC core: stream in instructions and preloads, stream out one result per request.
// Each request (an instruction, a register preload or a memory-byte preload) returns exactly one
// result, in order. The front end decodes requests into a two-entry queue, so it takes requests
// until full while the back end works or the output waits. The back end reads the register file
// into registers as it pops a request and retires it once the output is free: one request per
// cycle while the output accepts. A LOAD also passes through the MEM state for the memory read.
// After HALT, instructions only report the halted state; preloads still act.
module tiny_8bit_risc_core_top
    import trc_pkg::*;
#(
    parameter int MEM_BYTES = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // instruction[15:0], preload_index[23:16], preload_value[31:24]
    input  logic [31:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // next_pc[7:0], reg_written[8], written_reg[12:9], written_value[20:13],
    // mem_written[21], branch_taken[22], halted[23]
    output logic [23:0] o_m_axis_tdata
);

    logic    q_valid;
    t_item   q_head;
    logic    q_pop;
    t_result result;

    trc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_kind          (i_s_axis_tuser),
        .i_instruction   (i_s_axis_tdata[15:0]),
        .i_preload_index (i_s_axis_tdata[23:16]),
        .i_preload_value (i_s_axis_tdata[31:24]),
        .o_q_valid       (q_valid),
        .o_q_head        (q_head),
        .i_q_pop         (q_pop)
    );

    trc_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    // Pack the result, first field in the low bits
    assign o_m_axis_tdata = {result.halted, result.branch_taken, result.mem_written,
                             result.written_value, result.written_reg, result.reg_written,
                             result.next_pc};

endmodule

// ----- hdl/trc_front.sv -----
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
module trc_front
    import trc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_instruction,
    input  logic [7:0]  i_preload_index,
    input  logic [7:0]  i_preload_value,
    output logic        o_q_valid,
    output t_item       o_q_head,
    input  logic        i_q_pop
);

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        accept;
    t_item       dec;

    // Decode the instruction fields
    always_comb begin
        dec.kind = t_kind'(i_kind);
        dec.op   = t_opcode'(i_instruction[15:12]);
        dec.rd   = i_instruction[11:8];
        dec.rs   = i_instruction[7:4];
        dec.rt   = i_instruction[3:0];
        dec.pidx = i_preload_index;
        dec.pval = i_preload_value;
        // INC, STORE and BEQZ read the destination register on port B
        if (dec.op == OP_INC || dec.op == OP_STORE || dec.op == OP_BEQZ) begin
            dec.rb = dec.rd;
        end else begin
            dec.rb = dec.rt;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign accept    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_head  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!accept && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

// ----- hdl/trc_back.sv -----
// Back end: register file, data memory, execute sequencer and result register.
module trc_back
    import trc_pkg::*;
#(
    parameter int MEM_BYTES = 256
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_head,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int AW = $clog2(MEM_BYTES);

    // Reduce an 8-bit address modulo the memory size by conditional subtraction
    function automatic logic [AW-1:0] f_mem_index(input logic [7:0] addr);
        logic [11:0] v;
        v = {4'd0, addr};
        for (int k = 3; k >= 0; k--) begin
            if (v >= 12'(MEM_BYTES << k)) begin
                v = v - 12'(MEM_BYTES << k);
            end
        end
        return v[AW-1:0];
    endfunction

    t_state            r_state, n_state;
    t_item             r_cur;
    logic [7:0]        r_pc;
    logic              r_halt;
    logic              r_ov;
    t_result           r_res;

    logic [XLEN-1:0]   r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [XLEN-1:0]   r_rda, r_rdb;
    logic [XLEN-1:0]   r_dmem [MEM_BYTES];
    logic [XLEN-1:0]   r_memq;

    logic              out_free;
    logic              done;
    logic              go_mem;
    logic              halt_set;
    logic              exec_live;
    logic [7:0]        pc2;
    logic [XLEN-1:0]   alu;
    logic [15:0]       prod;
    logic [AW-1:0]     acc_addr;
    logic [REG_AW-1:0] ra_addr, rb_addr;
    logic              rf_we;
    logic [REG_AW-1:0] rf_wa;
    logic [XLEN-1:0]   rf_wd;
    logic              dm_we;
    logic [AW-1:0]     dm_wa;
    logic [XLEN-1:0]   dm_wd;
    t_result           res;

    assign out_free = !r_ov || i_ready;
    assign pc2      = r_pc + 8'd2;
    assign prod     = r_rda * r_rdb;
    assign acc_addr = f_mem_index(r_rda + {4'd0, r_cur.rt});
    assign exec_live = (r_cur.kind == KIND_EXEC) && !r_halt;

    // ALU
    always_comb begin
        unique case (r_cur.op)
            OP_ADD:  alu = r_rda + r_rdb;
            OP_SUB:  alu = r_rda - r_rdb;
            OP_MUL:  alu = prod[XLEN-1:0];
            OP_INC:  alu = r_rdb + 8'd1;
            OP_AND:  alu = r_rda & r_rdb;
            OP_OR:   alu = r_rda | r_rdb;
            OP_NOT:  alu = ~r_rda;
            OP_XOR:  alu = r_rda ^ r_rdb;
            OP_LOAD: alu = r_memq;
            default: alu = '0;
        endcase
    end

    // Result, write enables and retire condition
    always_comb begin
        res          = '0;
        res.next_pc  = r_pc;
        go_mem       = 1'b0;
        halt_set     = 1'b0;
        rf_we        = 1'b0;
        rf_wa        = r_cur.rd;
        rf_wd        = alu;
        dm_we        = 1'b0;
        dm_wa        = acc_addr;
        dm_wd        = r_rdb;

        priority if (exec_live) begin
            res.next_pc = pc2;
            unique case (r_cur.op)
                OP_ADD, OP_SUB, OP_MUL, OP_INC, OP_AND, OP_OR, OP_NOT, OP_XOR: begin
                    rf_we = 1'b1;
                end
                OP_LOAD: begin
                    rf_we  = 1'b1;
                    go_mem = (r_state == ST_EXEC);
                end
                OP_STORE: begin
                    dm_we = 1'b1;
                end
                OP_JMP: begin
                    res.next_pc      = pc2 + {r_cur.rd[2:0], r_cur.rs, 1'b0};
                    res.branch_taken = 1'b1;
                end
                OP_BEQZ: begin
                    if (r_rdb == '0) begin
                        res.next_pc      = pc2 + {r_cur.rs[2:0], r_cur.rt, 1'b0};
                        res.branch_taken = 1'b1;
                    end
                end
                OP_HALT: begin
                    halt_set = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (r_cur.kind == KIND_PRE_REG) begin
            rf_we = 1'b1;
            rf_wa = r_cur.pidx[REG_AW-1:0];
            rf_wd = r_cur.pval;
        end else if (r_cur.kind == KIND_PRE_MEM) begin
            dm_we = 1'b1;
            dm_wa = f_mem_index(r_cur.pidx);
            dm_wd = r_cur.pval;
        end else begin
        end

        res.reg_written   = rf_we && exec_live;
        res.written_reg   = res.reg_written ? r_cur.rd : '0;
        res.written_value = res.reg_written ? alu : '0;
        res.mem_written   = dm_we && exec_live;
        res.halted        = r_halt || halt_set;

        done  = ((r_state == ST_EXEC && !go_mem) || r_state == ST_MEM) && out_free;
        rf_we = rf_we && done;
        dm_we = dm_we && done;
    end

    // Sequencer next state and queue pop
    always_comb begin
        o_q_pop = i_q_valid && (r_state == ST_IDLE || done);
        n_state = r_state;
        if (o_q_pop) begin
            n_state = ST_EXEC;
        end else if (go_mem) begin
            n_state = ST_MEM;
        end else if (done) begin
            n_state = ST_IDLE;
        end
    end

    assign ra_addr = o_q_pop ? i_q_head.rs : r_cur.rs;
    assign rb_addr = o_q_pop ? i_q_head.rb : r_cur.rb;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= 8'd0;
            r_halt   <= 1'b0;
            r_ov     <= 1'b0;
            r_rf_vld <= '0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_pc   <= res.next_pc;
                r_halt <= res.halted;
                r_ov   <= 1'b1;
            end else if (i_ready) begin
                r_ov   <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
        end
    end

    // Current request and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_head;
        end
        if (done) begin
            r_res <= res;
        end
    end

    // Register file: one write port, two registered read ports with write bypass
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (rf_we && rf_wa == ra_addr) begin
            r_rda <= rf_wd;
        end else begin
            r_rda <= r_rf_vld[ra_addr] ? r_rf[ra_addr] : '0;
        end
        if (rf_we && rf_wa == rb_addr) begin
            r_rdb <= rf_wd;
        end else begin
            r_rdb <= r_rf_vld[rb_addr] ? r_rf[rb_addr] : '0;
        end
    end

    // Data memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_wa] <= dm_wd;
        end
        r_memq <= r_dmem[acc_addr];
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking stream testbench for the tiny 8-bit RISC core: random and directed requests.
`timescale 1ns / 1ps

module tb_top;
    import trc_pkg::*;

    localparam int MEM_BYTES = 256;
    localparam int HOLD_CYCLES = 200;

    // One request as queued for the driver, with its predicted result
    typedef struct {
        logic [7:0] next_pc;
        logic       reg_written;
        logic [3:0] written_reg;
        logic [7:0] written_value;
        logic       mem_written;
        logic       branch_taken;
        logic       halted;
    } t_core_result;

    typedef struct {
        t_kind        kind;
        logic [15:0]  instr;
        logic [7:0]   pidx;
        logic [7:0]   pval;
        int           gap;
        t_core_result want;
    } t_core_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // instruction[15:0], preload_index[23:16], preload_value[31:24]
    logic [31:0] i_s_axis_tdata = '0;
    // kind[1:0]
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // next_pc[7:0], reg_written[8], written_reg[12:9], written_value[20:13],
    // mem_written[21], branch_taken[22], halted[23]
    logic [23:0] o_m_axis_tdata;

    tiny_8bit_risc_core_top #(.MEM_BYTES(MEM_BYTES)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Shadow core state
    logic [7:0] core_regs [16];
    logic [7:0] core_mem  [MEM_BYTES];
    bit         mem_ok    [MEM_BYTES];
    logic [7:0] core_pc;
    bit         core_halt;

    t_core_req    pend_q[$];
    t_core_result result_q[$];

    bit gen_burst;
    int n_reqs, n_exec, err_cnt, got_cnt;

    function automatic int mem_slot(logic [7:0] a);
        return int'(a) % MEM_BYTES;
    endfunction

    // Apply one request to the shadow state and return what the core must report
    function automatic t_core_result core_exec(t_core_req r);
        t_core_result res;
        logic [3:0] op, d, s1, s2;
        logic [7:0] a, b, addr, v;
        res = '{default: '0};
        res.next_pc = core_pc;
        op = r.instr[15:12];
        d  = r.instr[11:8];
        s1 = r.instr[7:4];
        s2 = r.instr[3:0];
        v  = '0;
        if (r.kind == KIND_PRE_REG) begin
            core_regs[r.pidx[3:0]] = r.pval;
        end else if (r.kind == KIND_PRE_MEM) begin
            core_mem[mem_slot(r.pidx)] = r.pval;
            mem_ok[mem_slot(r.pidx)] = 1'b1;
        end else if (r.kind == KIND_EXEC && !core_halt) begin
            a = core_regs[s1];
            b = core_regs[s2];
            addr = a + {4'd0, s2};
            res.next_pc = core_pc + 8'd2;
            res.reg_written = 1'b1;
            case (op)
                OP_ADD:  v = a + b;
                OP_SUB:  v = a - b;
                OP_MUL:  v = a * b;
                OP_INC:  v = core_regs[d] + 8'd1;
                OP_AND:  v = a & b;
                OP_OR:   v = a | b;
                OP_NOT:  v = ~a;
                OP_XOR:  v = a ^ b;
                OP_LOAD: v = core_mem[mem_slot(addr)];
                default: res.reg_written = 1'b0;
            endcase
            if (res.reg_written) begin
                res.written_reg = d;
                res.written_value = v;
                core_regs[d] = v;
            end else begin
                case (op)
                    OP_STORE: begin
                        core_mem[mem_slot(addr)] = core_regs[d];
                        mem_ok[mem_slot(addr)] = 1'b1;
                        res.mem_written = 1'b1;
                    end
                    OP_JMP: begin
                        res.next_pc = core_pc + 8'd2 + {d, s1, 1'b0};
                        res.branch_taken = 1'b1;
                    end
                    OP_BEQZ: begin
                        if (core_regs[d] == 8'd0) begin
                            res.next_pc = core_pc + 8'd2 + {s1, s2, 1'b0};
                            res.branch_taken = 1'b1;
                        end
                    end
                    OP_HALT: core_halt = 1'b1;
                    default: ;
                endcase
            end
            core_pc = res.next_pc;
        end
        res.halted = core_halt;
        return res;
    endfunction

    // Queue a request; a LOAD from a byte never written gets a preload first
    task automatic add_item(t_kind k, logic [15:0] ins, logic [7:0] idx, logic [7:0] val);
        t_core_req r;
        logic [7:0] la;
        if (k == KIND_EXEC && !core_halt && ins[15:12] == OP_LOAD) begin
            la = core_regs[ins[7:4]] + {4'd0, ins[3:0]};
            if (!mem_ok[mem_slot(la)])
                add_item(KIND_PRE_MEM, 16'($urandom()), la, 8'($urandom()));
        end
        r.kind = k;
        r.instr = ins;
        r.pidx = idx;
        r.pval = val;
        r.gap = gen_burst ? 0 : $urandom_range(0, 3);
        r.want = core_exec(r);
        pend_q.push_back(r);
        n_reqs++;
        if (k == KIND_EXEC)
            n_exec++;
    endtask

    function automatic logic [15:0] mk_ins(t_opcode op, logic [3:0] d, logic [3:0] s1,
                                           logic [3:0] s2);
        return {op, d, s1, s2};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, got_cnt, got, want);
        err_cnt++;
    endtask

    // Driver: present queued requests, idle for each request's gap after it
    int        gap_left;
    t_core_req cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid)
                result_q.push_back(cur_req.want);
            if (gap_left > 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pend_q.size() != 0) begin
                cur_req = pend_q.pop_front();
                i_s_axis_tdata <= {cur_req.pval, cur_req.pidx, cur_req.instr};
                i_s_axis_tuser <= cur_req.kind;
                i_s_axis_tvalid <= 1'b1;
                gap_left <= cur_req.gap;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs, so the core fills up and stalls its input
    int hold_left, hold_fired;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_fired <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((hold_fired == 0 && got_cnt >= 300) ||
                     (hold_fired == 1 && got_cnt >= 900)) begin
            hold_left <= HOLD_CYCLES;
            hold_fired <= hold_fired + 1;
        end
    end

    // Monitor: take results, compare against the oldest prediction
    int           rx_wait;
    int           rx_draw;
    t_core_result got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait <= 0;
            got_cnt <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.next_pc       = o_m_axis_tdata[7:0];
            got.reg_written   = o_m_axis_tdata[8];
            got.written_reg   = o_m_axis_tdata[12:9];
            got.written_value = o_m_axis_tdata[20:13];
            got.mem_written   = o_m_axis_tdata[21];
            got.branch_taken  = o_m_axis_tdata[22];
            got.halted        = o_m_axis_tdata[23];
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", int'(o_m_axis_tdata), 0);
            end else begin
                want = result_q.pop_front();
                if (got.next_pc !== want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.reg_written !== want.reg_written)
                    report_mismatch("reg_written", got.reg_written, want.reg_written);
                if (got.written_reg !== want.written_reg)
                    report_mismatch("written_reg", got.written_reg, want.written_reg);
                if (got.written_value !== want.written_value)
                    report_mismatch("written_value", got.written_value, want.written_value);
                if (got.mem_written !== want.mem_written)
                    report_mismatch("mem_written", got.mem_written, want.mem_written);
                if (got.branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", got.branch_taken, want.branch_taken);
                if (got.halted !== want.halted)
                    report_mismatch("halted", got.halted, want.halted);
            end
            got_cnt <= got_cnt + 1;
            // stretches of back-to-back acceptance between random stalls
            rx_draw = ((got_cnt % 192) < 64) ? 0 : $urandom_range(0, 3);
            rx_wait <= rx_draw;
            i_m_axis_tready <= (rx_draw == 0) && (hold_left == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_m_axis_tready <= (rx_wait == 1) && (hold_left == 0);
        end else begin
            i_m_axis_tready <= (hold_left == 0);
        end
    end

    // Run limit
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int p;
        logic [3:0] op;
        for (int i = 0; i < 16; i++)
            core_regs[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++) begin
            core_mem[i] = '0;
            mem_ok[i] = 1'b0;
        end
        core_pc = '0;
        core_halt = 1'b0;
        gen_burst = 1'b0;

        // Directed: field extremes, each opcode but HALT, wrap and branch corners
        add_item(KIND_PRE_REG, 16'hFFFF, 8'hF1, 8'hFF);   // upper index bits ignored
        add_item(KIND_PRE_REG, 16'h0000, 8'h02, 8'h80);
        add_item(KIND_PRE_REG, 16'h0000, 8'h03, 8'h7F);
        add_item(KIND_PRE_REG, 16'h0000, 8'h0B, 8'hF8);
        add_item(KIND_PRE_MEM, 16'h0000, 8'hFF, 8'hA5);
        add_item(KIND_EXEC, mk_ins(OP_ADD, 4, 1, 2), 8'hFF, 8'hFF);
        add_item(KIND_EXEC, mk_ins(OP_SUB, 5, 2, 1), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_MUL, 6, 1, 1), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_INC, 1, 0, 0), 8'h00, 8'h00);   // 0xFF wraps to 0
        add_item(KIND_EXEC, mk_ins(OP_AND, 7, 2, 3), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_OR, 8, 2, 3), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_NOT, 9, 3, 0), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_XOR, 10, 2, 3), 8'h00, 8'h00);
        // address wraps past 255
        add_item(KIND_EXEC, mk_ins(OP_STORE, 3, 11, 15), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_LOAD, 12, 11, 15), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_LOAD, 13, 2, 0), 8'h00, 8'h00);
        add_item(KIND_EXEC, {OP_JMP, 8'h7F, 4'hF}, 8'h00, 8'h00);
        add_item(KIND_EXEC, {OP_JMP, 8'h80, 4'h0}, 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_BEQZ, 1, 4'hF, 4'hF), 8'h00, 8'h00);   // taken, back
        add_item(KIND_EXEC, mk_ins(OP_BEQZ, 3, 4'h7, 4'hF), 8'h00, 8'h00);   // not taken
        add_item(KIND_EXEC, 16'hC123, 8'h00, 8'h00);
        add_item(KIND_EXEC, 16'hD456, 8'h00, 8'h00);
        add_item(KIND_EXEC, 16'hE789, 8'h00, 8'h00);
        add_item(KIND_NONE, 16'hFFFF, 8'hFF, 8'hFF);

        // Random: mostly instructions, some preloads, a little unused kind
        for (int i = 0; i < 1400; i++) begin
            if (i % 100 == 0)
                gen_burst = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, 99);
            if (p < 78) begin
                op = 4'($urandom_range(0, 14));
                add_item(KIND_EXEC, {op, 12'($urandom())}, 8'($urandom()), 8'($urandom()));
            end else if (p < 97) begin
                add_item((p < 88) ? KIND_PRE_REG : KIND_PRE_MEM, 16'($urandom()),
                         8'($urandom()),
                         ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
            end else begin
                add_item(KIND_NONE, 16'($urandom()), 8'($urandom()), 8'($urandom()));
            end
        end

        // Halt, then show that instructions are dead and preloads still act
        add_item(KIND_EXEC, {OP_HALT, 12'($urandom())}, 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_INC, 0, 0, 0), 8'h00, 8'h00);
        add_item(KIND_EXEC, mk_ins(OP_LOAD, 0, 0, 0), 8'h00, 8'h00);
        add_item(KIND_PRE_REG, 16'h0000, 8'h05, 8'h5A);
        add_item(KIND_PRE_MEM, 16'h0000, 8'h10, 8'hC3);
        add_item(KIND_EXEC, {OP_JMP, 8'h01, 4'h0}, 8'h00, 8'h00);
        add_item(KIND_NONE, 16'h0000, 8'h00, 8'h00);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every queued request must come back as a result
        while (got_cnt < n_reqs)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Drove %0d requests (%0d instructions, rest preloads and unused kind),",
                 n_reqs, n_exec);
        $display("checked %0d results with %0d receiver hold-offs, %0d mismatches.",
                 got_cnt, hold_fired, err_cnt);
        if (err_cnt == 0 && got_cnt == n_reqs)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- tiny_8bit_risc_core_top.f -----
hdl/trc_pkg.sv
hdl/trc_front.sv
hdl/trc_back.sv
hdl/tiny_8bit_risc_core_top.sv
verif/tb_top.sv
